// File: rtl/pdf_pkg.sv
// shared types, codes and the crc step function of the packet deframer
package pdf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned TDATA_W = 4 * BYTE_W + CRC_W + 5 * CNT_W;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VEHICLE     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_MASK    = 8'd3;

    typedef enum logic [3:0] {
        PH_SYNC1 = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_VEH   = 4'd2,
        PH_TGT   = 4'd3,
        PH_SRC   = 4'd4,
        PH_MID   = 4'd5,
        PH_SIZE  = 4'd6,
        PH_PAY   = 4'd7,
        PH_IDXL  = 4'd8,
        PH_IDXH  = 4'd9,
        PH_CRCL  = 4'd10,
        PH_CRCH  = 4'd11
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE = 3'd0,
        EV_DATA = 3'd1,
        EV_GOOD = 3'd2,
        EV_CRC  = 3'd3,
        EV_HDR  = 3'd4,
        EV_VEH  = 3'd5,
        EV_NFU  = 3'd6
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] vehicle;
        logic [BYTE_W-1:0] own_mask;
    } cfg_t;

    typedef struct packed {
        event_t             event_res;
        logic [BYTE_W-1:0]  data_byte;
        logic [BYTE_W-1:0]  sender_id;
        logic [BYTE_W-1:0]  message_id;
        logic [BYTE_W-1:0]  payload_length;
        logic [CRC_W-1:0]   packet_index;
        logic [CNT_W-1:0]   good_count;
        logic [CNT_W-1:0]   crc_error_count;
        logic [CNT_W-1:0]   header_error_count;
        logic [CNT_W-1:0]   vehicle_error_count;
        logic [CNT_W-1:0]   received_count;
    } result_t;

    // one byte of the reflected 0x1021 crc, table-free form
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = b ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
    endfunction

endpackage

// File: rtl/pdf_cfg_regs.sv
// configuration register bank of the packet deframer
module pdf_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pdf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pdf_pkg::BYTE_W-1:0]         cfg_data,
    output pdf_pkg::cfg_t                      cfg
);
    import pdf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg_data;
                CFG_SYNC_SECOND: cfg_next.sync_second = cfg_data;
                CFG_VEHICLE:     cfg_next.vehicle     = cfg_data;
                CFG_OWN_MASK:    cfg_next.own_mask    = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/pdf_parser.sv
// packet parse state machine, running crc, header registers and counters
module pdf_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [pdf_pkg::BYTE_W-1:0]  rx_byte,
    input  pdf_pkg::cfg_t               cfg,
    output pdf_pkg::result_t            result
);
    import pdf_pkg::*;

    phase_t             phase_reg,   phase_next;
    logic [BYTE_W-1:0]  count_reg,   count_next;
    logic [CRC_W-1:0]   crc_reg,     crc_next;
    logic [BYTE_W-1:0]  length_reg,  length_next;
    logic [BYTE_W-1:0]  sender_reg,  sender_next;
    logic [BYTE_W-1:0]  msgid_reg,   msgid_next;
    logic [CRC_W-1:0]   index_reg,   index_next;
    logic [BYTE_W-1:0]  crc_low_reg, crc_low_next;
    logic [CNT_W-1:0]   good_reg,    good_next;
    logic [CNT_W-1:0]   crc_err_reg, crc_err_next;
    logic [CNT_W-1:0]   hdr_err_reg, hdr_err_next;
    logic [CNT_W-1:0]   veh_err_reg, veh_err_next;
    logic [CNT_W-1:0]   bytes_reg,   bytes_next;

    logic [CRC_W-1:0]   crc_upd;
    logic [BYTE_W-1:0]  count_inc;
    logic               crc_match;
    logic               target_hit;
    event_t             ev;
    logic [BYTE_W-1:0]  data;

    assign crc_upd    = crc_step((phase_reg == PH_SYNC1) ? '0 : crc_reg, rx_byte);
    assign count_inc  = count_reg + 8'd1;
    assign crc_match  = ({rx_byte, crc_low_reg} == crc_reg);
    assign target_hit = ((rx_byte & cfg.own_mask) != '0);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SYNC1: phase_next = (rx_byte == cfg.sync_first)  ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2: phase_next = (rx_byte == cfg.sync_second) ? PH_VEH   : PH_SYNC1;
            PH_VEH:   phase_next = (rx_byte == cfg.vehicle)     ? PH_TGT   : PH_SYNC1;
            PH_TGT:   phase_next = target_hit ? PH_SRC : PH_SYNC1;
            PH_SRC:   phase_next = PH_MID;
            PH_MID:   phase_next = PH_SIZE;
            PH_SIZE:  phase_next = (rx_byte == '0) ? PH_IDXL : PH_PAY;
            PH_PAY:   phase_next = (count_inc >= length_reg) ? PH_IDXL : PH_PAY;
            PH_IDXL:  phase_next = PH_IDXH;
            PH_IDXH:  phase_next = PH_CRCL;
            PH_CRCL:  phase_next = PH_CRCH;
            PH_CRCH:  phase_next = PH_SYNC1;
            default:  phase_next = PH_SYNC1;
        endcase
    end

    // event, datapath and counter updates
    always_comb begin
        ev           = EV_NONE;
        data         = '0;
        count_next   = count_reg;
        crc_next     = crc_reg;
        length_next  = length_reg;
        sender_next  = sender_reg;
        msgid_next   = msgid_reg;
        index_next   = index_reg;
        crc_low_next = crc_low_reg;
        good_next    = good_reg;
        crc_err_next = crc_err_reg;
        hdr_err_next = hdr_err_reg;
        veh_err_next = veh_err_reg;
        bytes_next   = bytes_reg + 32'd1;
        unique case (phase_reg)
            PH_SYNC1: begin
                if (rx_byte == cfg.sync_first) begin
                    crc_next = crc_upd;
                end else begin
                    hdr_err_next = hdr_err_reg + 32'd1;
                    ev = EV_HDR;
                end
            end
            PH_SYNC2: begin
                if (rx_byte == cfg.sync_second) begin
                    crc_next = crc_upd;
                end else begin
                    hdr_err_next = hdr_err_reg + 32'd1;
                    ev = EV_HDR;
                end
            end
            PH_VEH: begin
                if (rx_byte == cfg.vehicle) begin
                    crc_next = crc_upd;
                end else begin
                    veh_err_next = veh_err_reg + 32'd1;
                    ev = EV_VEH;
                end
            end
            PH_TGT: begin
                if (target_hit) begin
                    crc_next = crc_upd;
                end else begin
                    ev = EV_NFU;
                end
            end
            PH_SRC: begin
                sender_next = rx_byte;
                crc_next = crc_upd;
            end
            PH_MID: begin
                msgid_next = rx_byte;
                crc_next = crc_upd;
            end
            PH_SIZE: begin
                length_next = rx_byte;
                crc_next = crc_upd;
                count_next = '0;
            end
            PH_PAY: begin
                crc_next = crc_upd;
                ev = EV_DATA;
                data = rx_byte;
                count_next = (count_inc >= length_reg) ? '0 : count_inc;
            end
            // low index byte starts a fresh index, high byte cleared
            PH_IDXL: index_next = {8'h00, rx_byte};
            PH_IDXH: index_next = {rx_byte, index_reg[7:0]};
            PH_CRCL: crc_low_next = rx_byte;
            PH_CRCH: begin
                if (crc_match) begin
                    good_next = good_reg + 32'd1;
                    ev = EV_GOOD;
                end else begin
                    crc_err_next = crc_err_reg + 32'd1;
                    ev = EV_CRC;
                end
            end
            default: ev = EV_NONE;
        endcase
    end

    always_comb begin
        result.event_res           = ev;
        result.data_byte           = data;
        result.sender_id           = sender_next;
        result.message_id          = msgid_next;
        result.payload_length      = length_next;
        result.packet_index        = index_next;
        result.good_count          = good_next;
        result.crc_error_count     = crc_err_next;
        result.header_error_count  = hdr_err_next;
        result.vehicle_error_count = veh_err_next;
        result.received_count      = bytes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SYNC1;
            count_reg   <= '0;
            crc_reg     <= '0;
            length_reg  <= '0;
            sender_reg  <= '0;
            msgid_reg   <= '0;
            index_reg   <= '0;
            crc_low_reg <= '0;
            good_reg    <= '0;
            crc_err_reg <= '0;
            hdr_err_reg <= '0;
            veh_err_reg <= '0;
            bytes_reg   <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            length_reg  <= length_next;
            sender_reg  <= sender_next;
            msgid_reg   <= msgid_next;
            index_reg   <= index_next;
            crc_low_reg <= crc_low_next;
            good_reg    <= good_next;
            crc_err_reg <= crc_err_next;
            hdr_err_reg <= hdr_err_next;
            veh_err_reg <= veh_err_next;
            bytes_reg   <= bytes_next;
        end
    end

endmodule

// File: rtl/packet_deframer_crc16.sv
// top level of the sync-header packet deframer with crc-16 check
// an s_ word passes the input register, then the parse step, then the result register on m_
// throughput: one word per cycle unless m_ stalls, one parse step from input to result register
// every received word gives exactly one result word
// reset: synchronous active-low aresetn clears parse state, counters, config and both valid flags
module packet_deframer_crc16 (
    input  logic                               aclk,
    input  logic                               aresetn,
    // received word stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pdf_pkg::BYTE_W-1:0]         s_tdata,    // [7:0] rx_byte
    // result word stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] data_byte, [15:8] sender_id, [23:16] message_id, [31:24] payload_length,
    // [47:32] packet_index, [79:48] good_count, [111:80] crc_error_count,
    // [143:112] header_error_count, [175:144] vehicle_error_count,
    // [207:176] received_count
    output logic [pdf_pkg::TDATA_W-1:0]        m_tdata,
    output logic [pdf_pkg::EVENT_W-1:0]        m_tuser,    // [2:0] event_res
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pdf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pdf_pkg::BYTE_W-1:0]         cfg_data
);
    import pdf_pkg::*;

    // input register stage
    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;

    // result register stage
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    cfg_t               cfg;
    result_t            result;
    logic               advance;    // result register can take a new word
    logic               step;       // parse the word held in the input register

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    pdf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {out_reg.received_count,
                       out_reg.vehicle_error_count,
                       out_reg.header_error_count,
                       out_reg.crc_error_count,
                       out_reg.good_count,
                       out_reg.packet_index,
                       out_reg.payload_length,
                       out_reg.message_id,
                       out_reg.sender_id,
                       out_reg.data_byte};

endmodule
